>>> rtl/core/pps_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pps_pkg
// Task record, field widths and helpers shared by the scheduler core and its
// ready table.
// ----------------------------------------------------------------------------
package pps_pkg;

	localparam int ID_W   = 8;
	localparam int PRIO_W = 8;
	localparam int LEFT_W = 16;
	localparam int TASK_W = ID_W + PRIO_W + LEFT_W;

	// stream payload widths
	localparam int IN_DATA_W  = 32;
	localparam int OUT_DATA_W = 32;
	localparam int OUT_USED_W = 1 + ID_W + LEFT_W + 1;

	// function codes carried in tuser
	localparam logic FUNC_TICK   = 1'b0;
	localparam logic FUNC_ARRIVE = 1'b1;

	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [PRIO_W-1:0] prio;
		logic [LEFT_W-1:0] left;
	} task_t;

	// saturating decrement of remaining ticks
	function automatic task_t dec_left(input task_t t);
		task_t r;
		r = t;
		if (t.left != '0) begin
			r.left = t.left - LEFT_W'(1);
		end
		return r;
	endfunction

endpackage
`default_nettype wire

>>> rtl/core/pps_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pps_table
// Ready table storage: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module pps_table import pps_pkg::*; #(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire task_t         wdata,
	input  wire logic [AW-1:0] raddr,
	output task_t              rdata
);

	task_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

>>> rtl/core/preemptive_priority_scheduler_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler_top
// Preemptive priority scheduler with a ready table scanned one entry a cycle.
// ----------------------------------------------------------------------------
//  channel   | dir | tdata (low bit up)                        | tuser
//  s_axis    | in  | task_id[7:0] task_priority[15:8] run_time  | func
//  m_axis    | out | running_valid running_id running_left ovf  | -
//
//  Arrival, or tick that needs no table pull: accept, then emit.
//  Tick that pulls from the table: all ready entries are scanned through the
//  single read port, entries above the winner are shifted down one slot
//  (compaction), then the result is emitted.
//  Reset clears run state and the entry count; table contents need no clear.
//  One item at a time; a finished result waits in the output register while
//  the next item is taken, and the emit step waits while that register is full.
// ----------------------------------------------------------------------------
module preemptive_priority_scheduler_top import pps_pkg::*; #(
	parameter int READY_SLOTS = 16
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_axis_tvalid,
	output logic                       s_axis_tready,
	input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,  // task_id, task_priority, run_time
	input  wire logic                  s_axis_tuser,  // func
	output logic                       m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	output logic [OUT_DATA_W-1:0]      m_axis_tdata   // running_valid, running_id,
	                                                  // running_left, overflow
);

	localparam int CW = $clog2(READY_SLOTS + 1);
	localparam int IW = $clog2(READY_SLOTS);
	localparam logic [CW-1:0] SLOTS_C = CW'(READY_SLOTS);

	typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_SHIFT, ST_EMIT} state_t;

	state_t          state_q;
	logic            run_valid_q;
	task_t           run_q;
	logic [CW-1:0]   cnt_q;
	logic            ovf_q;
	logic [CW-1:0]   rd_idx_q;
	logic            pv_q;
	logic [IW-1:0]   cmp_idx_q;
	task_t           best_q;
	logic [IW-1:0]   best_idx_q;

	task_t           newcomer;
	task_t           rd_data;
	logic            accept;
	logic            preempt;
	logic            issue;
	logic            take;
	task_t           best_nx;
	logic [IW-1:0]   best_idx_nx;
	logic            scan_last;
	logic            mem_we;
	logic [IW-1:0]   mem_wa;
	task_t           mem_wd;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign newcomer      = task_t'({s_axis_tdata[ID_W-1:0],
		s_axis_tdata[ID_W+PRIO_W-1:ID_W], s_axis_tdata[TASK_W-1:ID_W+PRIO_W]});
	assign preempt       = run_valid_q && (newcomer.prio > run_q.prio);

	// shared compare unit
	assign issue       = rd_idx_q < cnt_q;
	assign take        = (cmp_idx_q == '0) || (rd_data.prio > best_q.prio);
	assign best_nx     = take ? rd_data : best_q;
	assign best_idx_nx = take ? cmp_idx_q : best_idx_q;
	assign scan_last   = pv_q && ((CW'(cmp_idx_q) + CW'(1)) == cnt_q);

	always_comb begin
		mem_we = 1'b0;
		mem_wa = cnt_q[IW-1:0];
		mem_wd = newcomer;
		if (state_q == ST_IDLE && accept && s_axis_tuser == FUNC_ARRIVE &&
			cnt_q != SLOTS_C) begin
			mem_we = 1'b1;
			mem_wd = preempt ? run_q : newcomer;
		end else if (state_q == ST_SHIFT && pv_q) begin
			mem_we = 1'b1;
			mem_wa = cmp_idx_q - IW'(1);
			mem_wd = rd_data;
		end
	end

	pps_table #(
		.DEPTH (READY_SLOTS),
		.AW    (IW)
	) u_table (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_wa),
		.wdata (mem_wd),
		.raddr (rd_idx_q[IW-1:0]),
		.rdata (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			run_valid_q   <= 1'b0;
			run_q         <= '0;
			cnt_q         <= '0;
			ovf_q         <= 1'b0;
			rd_idx_q      <= '0;
			pv_q          <= 1'b0;
			cmp_idx_q     <= '0;
			best_q        <= '0;
			best_idx_q    <= '0;
			m_axis_tvalid <= 1'b0;
			m_axis_tdata  <= '0;
		end else begin
			if (m_axis_tvalid && m_axis_tready && state_q != ST_EMIT) begin
				m_axis_tvalid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						ovf_q <= (s_axis_tuser == FUNC_ARRIVE) && (cnt_q == SLOTS_C);
						if (s_axis_tuser == FUNC_ARRIVE) begin
							if (cnt_q != SLOTS_C) begin
								cnt_q <= cnt_q + CW'(1);
								if (preempt) begin
									run_q <= newcomer;
								end
							end
							state_q <= ST_EMIT;
						end else if (run_valid_q && run_q.left != '0) begin
							run_q   <= dec_left(run_q);
							state_q <= ST_EMIT;
						end else if (cnt_q != '0) begin
							rd_idx_q <= '0;
							pv_q     <= 1'b0;
							state_q  <= ST_SCAN;
						end else begin
							run_valid_q <= 1'b0;
							run_q       <= '0;
							state_q     <= ST_EMIT;
						end
					end
				end
				ST_SCAN: begin
					cmp_idx_q <= rd_idx_q[IW-1:0];
					if (pv_q) begin
						best_q     <= best_nx;
						best_idx_q <= best_idx_nx;
					end
					if (scan_last) begin
						rd_idx_q <= CW'(best_idx_nx) + CW'(1);
						pv_q     <= 1'b0;
						state_q  <= ST_SHIFT;
					end else begin
						rd_idx_q <= rd_idx_q + CW'(issue);
						pv_q     <= issue;
					end
				end
				ST_SHIFT: begin
					rd_idx_q  <= rd_idx_q + CW'(issue);
					pv_q      <= issue;
					cmp_idx_q <= rd_idx_q[IW-1:0];
					if (!issue && !pv_q) begin
						cnt_q       <= cnt_q - CW'(1);
						run_q       <= dec_left(best_q);
						run_valid_q <= 1'b1;
						state_q     <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (!m_axis_tvalid || m_axis_tready) begin
						m_axis_tvalid <= 1'b1;
						m_axis_tdata  <= {
							(OUT_DATA_W - OUT_USED_W)'(0),
							ovf_q,
							run_valid_q ? run_q.left : LEFT_W'(0),
							run_valid_q ? run_q.id : ID_W'(0),
							run_valid_q
						};
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= SLOTS_C)
		else $error("ready count above table size");

	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		##1 (cnt_q == $past(cnt_q) || cnt_q == $past(cnt_q) + CW'(1) ||
		cnt_q + CW'(1) == $past(cnt_q)))
		else $error("ready count moved by more than one");

	a_scan_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN || state_q == ST_SHIFT) |-> cnt_q != '0)
		else $error("table walk with empty table");

	a_shift_wr: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SHIFT && pv_q) |-> (cmp_idx_q != '0 &&
		CW'(cmp_idx_q) < cnt_q))
		else $error("compaction write out of range");

endmodule
`default_nettype wire
